>>> rtl/midpoint_ellipse_generator_assert.svh
// Assertion macros for the midpoint ellipse generator.
// Used by the top level; no other dependencies.
`ifndef MIDPOINT_ELLIPSE_GENERATOR_ASSERT_SVH
`define MIDPOINT_ELLIPSE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MEG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ellipse generator check failed");
// next-cycle implication
`define MEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ellipse generator check failed");
`else
`define MEG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MEG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/meg_pkg.sv
// Shared constants and types for the midpoint ellipse generator.
// No dependencies.
`default_nettype none

package meg_pkg;

  // coordinate width of center registers
  localparam int COORD_BITS = 12;
  localparam int AXIS_W     = COORD_BITS - 1;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int SQ_W       = 2 * AXIS_W;          // squared semi-axis
  localparam int MUL_A_W    = 2 * COORD_BITS + 2;
  localparam int MUL_B_W    = 2 * COORD_BITS;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int STEP_W     = 3 * COORD_BITS + 1;  // step_px / step_py
  localparam int DEC_W      = 4 * COORD_BITS + 4;  // signed decision
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_SEMI_AXIS_X = 3'd2,
    REG_SEMI_AXIS_Y = 3'd3,
    REG_DRAW_COLOR  = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/meg_in_if.sv
// Input channel of the ellipse generator: one restart/advance word.
// No dependencies.
`default_nettype none

interface meg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> rtl/meg_out_if.sv
// Result channel of the ellipse generator: four coordinates, color, done.
// Depends on meg_pkg.
`default_nettype none

interface meg_out_if;
  import meg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_right;
  logic signed [OUT_W-1:0] x_left;
  logic signed [OUT_W-1:0] y_lower;
  logic signed [OUT_W-1:0] y_upper;
  logic [COLOR_W-1:0]      pixel_color;
  logic                    done_res;

  modport source (output valid, output x_right, output x_left, output y_lower,
                  output y_upper, output pixel_color, output done_res, input ready);
  modport sink   (input valid, input x_right, input x_left, input y_lower,
                  input y_upper, input pixel_color, input done_res, output ready);
endinterface

`default_nettype wire

>>> rtl/meg_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on meg_pkg.
`default_nettype none

interface meg_cfg_if;
  import meg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/meg_mul.sv
// Shared registered multiplier of the ellipse generator.
// Depends on meg_pkg.
`default_nettype none

module meg_mul (
  input  logic                         clk,
  input  logic [meg_pkg::MUL_A_W-1:0]  a,
  input  logic [meg_pkg::MUL_B_W-1:0]  b,
  output logic [meg_pkg::PROD_W-1:0]   prod
);
  import meg_pkg::*;

  // unsigned product, registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

>>> rtl/midpoint_ellipse_generator.sv
// Top level of the midpoint ellipse generator.
// Depends on meg_pkg, meg_in_if, meg_out_if, meg_cfg_if, meg_mul and the assert header.
`default_nettype none
`include "midpoint_ellipse_generator_assert.svh"

// Midpoint ellipse rasterizer. Program center, semi-axes and color through the
// cfg channel (always ready), then send a word with restart=1 to start an
// ellipse and words with restart=0 to advance one step; every word returns one
// result word with the four symmetric pixels, the color and a done flag.
// The block takes one word at a time and is busy until its result is loaded
// into the output register. The busy time comes from the single registered
// multiplier, which squares both semi-axes for each word but an advance after
// done and forms the region-two starting decision in five chained products,
// and from the step update being split into step, term and accumulate states.
// A stalled result register keeps the block busy until ready is seen.
module midpoint_ellipse_generator (
  input  logic      clk,
  input  logic      rst,
  meg_in_if.sink    item,
  meg_out_if.source result,
  meg_cfg_if.sink   cfg
);
  import meg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_DISP, S_RST,
    S_TA, S_TB, S_TC, S_TD, S_TE,
    S_STEP, S_TERM, S_ACC, S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [AXIS_W-1:0]     semi_axis_x;
  logic [AXIS_W-1:0]     semi_axis_y;
  logic [COLOR_W-1:0]    draw_color;

  // walk state; step_py can drop below zero when the axes change mid-ellipse
  logic [COORD_BITS-1:0]    offset_x;
  logic [COORD_BITS-1:0]    offset_y;
  logic signed [STEP_W-1:0] step_px;
  logic signed [STEP_W-1:0] step_py;
  logic signed [DEC_W-1:0]  decision;
  logic signed [DEC_W-1:0]  term;
  logic                     in_region_two;
  logic                     finished;
  logic                     restart_req;
  logic                     dec_neg;
  logic [SQ_W-1:0]          rx2;
  logic [SQ_W-1:0]          ry2;

  // output register
  logic                    out_valid;
  logic signed [OUT_W-1:0] x_right;
  logic signed [OUT_W-1:0] x_left;
  logic signed [OUT_W-1:0] y_lower;
  logic signed [OUT_W-1:0] y_upper;
  logic [COLOR_W-1:0]      pixel_color;
  logic                    done_res;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic [COORD_BITS:0]      ax;       // 2x+1
  logic [COORD_BITS-1:0]    by;       // y-1
  logic [STEP_W-1:0]        two_rx2;
  logic [STEP_W-1:0]        two_ry2;
  logic signed [STEP_W-1:0] term_add;
  logic signed [STEP_W-1:0] term_sub;
  logic [SQ_W-1:0]          term_base;
  logic                     load_out;

  assign ax      = {offset_x, 1'b1};
  assign by      = offset_y - COORD_BITS'(1);
  assign two_rx2 = STEP_W'(rx2) << 1;
  assign two_ry2 = STEP_W'(ry2) << 1;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign load_out   = (state == S_EMIT) && (!out_valid || result.ready);

  assign result.valid       = out_valid;
  assign result.x_right     = x_right;
  assign result.x_left      = x_left;
  assign result.y_lower     = y_lower;
  assign result.y_upper     = y_upper;
  assign result.pixel_color = pixel_color;
  assign result.done_res    = done_res;

  // multiplier operand select per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX: begin
        mul_a = MUL_A_W'(semi_axis_x);
        mul_b = MUL_B_W'(semi_axis_x);
      end
      S_SQY: begin
        mul_a = MUL_A_W'(semi_axis_y);
        mul_b = MUL_B_W'(semi_axis_y);
      end
      S_DISP: begin
        if (restart_req) begin
          mul_a = MUL_A_W'(rx2);
          mul_b = MUL_B_W'(semi_axis_y);
        end else begin
          mul_a = MUL_A_W'(ax);
          mul_b = MUL_B_W'(ax);
        end
      end
      S_TA: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(ry2);
      end
      S_TB: begin
        mul_a = MUL_A_W'(by);
        mul_b = MUL_B_W'(by);
      end
      S_TC: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(rx2);
      end
      S_TD: begin
        mul_a = MUL_A_W'(rx2);
        mul_b = MUL_B_W'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  meg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // decision increment operands: region one and region two share one adder
  always_comb begin
    if (in_region_two) begin
      term_base = rx2;
      term_add  = dec_neg ? step_px : '0;
      term_sub  = step_py;
    end else begin
      term_base = ry2;
      term_add  = step_px;
      term_sub  = dec_neg ? '0 : step_py;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      semi_axis_x <= '0;
      semi_axis_y <= '0;
      draw_color  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_CENTER_X:    center_x    <= cfg.data[COORD_BITS-1:0];
        REG_CENTER_Y:    center_y    <= cfg.data[COORD_BITS-1:0];
        REG_SEMI_AXIS_X: semi_axis_x <= cfg.data[AXIS_W-1:0];
        REG_SEMI_AXIS_Y: semi_axis_y <= cfg.data[AXIS_W-1:0];
        REG_DRAW_COLOR:  draw_color  <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, walk state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      offset_x      <= '0;
      offset_y      <= '0;
      step_px       <= '0;
      step_py       <= '0;
      decision      <= '0;
      in_region_two <= 1'b0;
      finished      <= 1'b1;
      restart_req   <= 1'b0;
      dec_neg       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // output word: load takes priority over the drain of the previous word
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            restart_req <= item.restart;
            state       <= (item.restart || !finished) ? S_SQX : S_EMIT;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          rx2   <= prod[SQ_W-1:0];
          state <= S_DISP;
        end
        S_DISP: begin
          ry2 <= prod[SQ_W-1:0];
          if (restart_req) begin
            state <= S_RST;
          end else if (!in_region_two && (step_px < step_py)) begin
            state <= S_STEP;
          end else if (!in_region_two) begin
            state <= S_TA;
          end else begin
            state <= S_STEP;
          end
        end
        // new ellipse: prod holds rx2*ry
        S_RST: begin
          offset_x      <= '0;
          offset_y      <= COORD_BITS'(semi_axis_y);
          step_px       <= '0;
          step_py       <= STEP_W'(prod) << 1;
          decision      <= $signed(DEC_W'(ry2) << 2) - $signed(DEC_W'(prod) << 2)
                           + $signed(DEC_W'(rx2));
          in_region_two <= 1'b0;
          finished      <= (semi_axis_y == '0);
          state         <= S_EMIT;
        end
        // region-two start decision, one product per cycle
        S_TA: state <= S_TB;
        S_TB: begin
          decision <= $signed(DEC_W'(prod));
          state    <= S_TC;
        end
        S_TC: state <= S_TD;
        S_TD: begin
          decision <= decision + $signed(DEC_W'(prod) << 2);
          state    <= S_TE;
        end
        S_TE: begin
          decision      <= decision - $signed(DEC_W'(prod) << 2);
          in_region_two <= 1'b1;
          state         <= S_STEP;
        end
        // position and slope update
        S_STEP: begin
          dec_neg <= decision < 0;
          if (!in_region_two) begin
            offset_x <= offset_x + COORD_BITS'(1);
            step_px  <= step_px + two_ry2;
            if (decision >= 0) begin
              offset_y <= offset_y - COORD_BITS'(1);
              step_py  <= step_py - two_rx2;
            end
            state <= S_TERM;
          end else if (offset_y == '0) begin
            state <= S_EMIT;
          end else begin
            step_py  <= step_py - two_rx2;
            offset_y <= offset_y - COORD_BITS'(1);
            if (decision < 0) begin
              offset_x <= offset_x + COORD_BITS'(1);
              step_px  <= step_px + two_ry2;
            end
            state <= S_TERM;
          end
        end
        S_TERM: begin
          term  <= $signed(DEC_W'(term_base)) + $signed(DEC_W'(term_add))
                   - $signed(DEC_W'(term_sub));
          state <= S_ACC;
        end
        S_ACC: begin
          decision <= decision + (term <<< 2);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            x_right     <= $signed(OUT_W'(center_x) + OUT_W'(offset_x));
            x_left      <= $signed(OUT_W'(center_x) - OUT_W'(offset_x));
            y_lower     <= $signed(OUT_W'(center_y) + OUT_W'(offset_y));
            y_upper     <= $signed(OUT_W'(center_y) - OUT_W'(offset_y));
            pixel_color <= draw_color;
            done_res    <= (offset_y == '0);
            finished    <= (offset_y == '0);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `MEG_ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, state != S_IDLE)
  `MEG_ASSERT_IMPL(a_done_on_axis, clk, rst, result.valid && result.done_res, result.y_lower == result.y_upper)
  `MEG_ASSERT_IMPL(a_finished_at_zero, clk, rst, finished, offset_y == '0)
  `MEG_ASSERT_NEXT(a_region_two_sticky, clk, rst, in_region_two && state != S_RST, in_region_two)

endmodule

`default_nettype wire

>>> bench/midpoint_ellipse_generator_test.sv
// Self-checking bench for midpoint_ellipse_generator: restart/advance words go in,
// an ellipse walk kept inside the bench predicts each result word, and a monitor checks it.
// Depends on meg_pkg and the meg_in_if, meg_out_if and meg_cfg_if interfaces.
module midpoint_ellipse_generator_test;
  import meg_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake at all
  localparam int ITEM_COUNT = 1100;
  localparam int CALM_FROM  = 950;    // no idling on either side from here on
  localparam int REG_COUNT  = 5;      // registers that exist; higher indexes are ignored
  localparam int REPORT_CAP = 50;
  localparam int MAX_ADVANCE = 60;    // cap on one run of advance words

  typedef struct packed {
    logic signed [OUT_W-1:0] x_right;
    logic signed [OUT_W-1:0] x_left;
    logic signed [OUT_W-1:0] y_lower;
    logic signed [OUT_W-1:0] y_upper;
    logic [COLOR_W-1:0]      color;
    logic                    done;
  } ellipse_point_t;

  // Tracks the register file and the rasterizer walk, and holds the points
  // still owed by the block.
  class ellipse_tracker;
    logic [COORD_BITS-1:0] center_x, center_y;
    logic [AXIS_W-1:0]     semi_x, semi_y;
    logic [COLOR_W-1:0]    color;
    longint off_x, off_y, step_px, step_py, decision;
    bit region_two, finished;
    ellipse_point_t expected_points[$];
    int mismatches;

    function new();
      center_x = '0;
      center_y = '0;
      semi_x = '0;
      semi_y = '0;
      color = '0;
      off_x = 0;
      off_y = 0;
      step_px = 0;
      step_py = 0;
      decision = 0;
      region_two = 0;
      finished = 1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_CENTER_X:    center_x = data[COORD_BITS-1:0];
        REG_CENTER_Y:    center_y = data[COORD_BITS-1:0];
        REG_SEMI_AXIS_X: semi_x = data[AXIS_W-1:0];
        REG_SEMI_AXIS_Y: semi_y = data[AXIS_W-1:0];
        REG_DRAW_COLOR:  color = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Move the walk by one accepted word and queue the point it yields.
    function void note_word(bit restart);
      longint rx, ry, rx2, ry2, a, b, sum;
      ellipse_point_t p;
      rx = longint'(semi_x);
      ry = longint'(semi_y);
      rx2 = rx * rx;
      ry2 = ry * ry;
      if (restart) begin
        off_x = 0;
        off_y = ry;
        step_px = 0;
        step_py = 2 * rx2 * ry;
        decision = 4 * ry2 - 4 * rx2 * ry + rx2;
        region_two = 0;
        finished = (off_y == 0);
      end else if (!finished) begin
        if (!region_two && step_px < step_py) begin
          // region one: x always steps
          off_x += 1;
          step_px += 2 * ry2;
          if (decision < 0) begin
            decision += 4 * (ry2 + step_px);
          end else begin
            off_y -= 1;
            step_py -= 2 * rx2;
            decision += 4 * (ry2 + step_px - step_py);
          end
        end else begin
          // entering region two: fresh decision, then step in the same word
          if (!region_two) begin
            a = 2 * off_x + 1;
            b = off_y - 1;
            region_two = 1;
            decision = ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2;
          end
          if (off_y <= 0) begin
            off_y = 0;
          end else begin
            step_py -= 2 * rx2;
            if (decision < 0) begin
              off_x += 1;
              step_px += 2 * ry2;
              decision += 4 * (rx2 - step_py + step_px);
            end else begin
              decision += 4 * (rx2 - step_py);
            end
            off_y -= 1;
          end
        end
        off_x = off_x & ((longint'(1) << COORD_BITS) - 1);
        finished = (off_y == 0);
      end
      // four symmetric pixels around the current center
      sum = longint'(center_x) + off_x;
      p.x_right = sum[OUT_W-1:0];
      sum = longint'(center_x) - off_x;
      p.x_left = sum[OUT_W-1:0];
      sum = longint'(center_y) + off_y;
      p.y_lower = sum[OUT_W-1:0];
      sum = longint'(center_y) - off_y;
      p.y_upper = sum[OUT_W-1:0];
      p.color = color;
      p.done = (off_y == 0);
      expected_points.push_back(p);
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_point(ellipse_point_t got);
      ellipse_point_t want;
      if (expected_points.size() == 0) begin
        flag_mismatch("result word with nothing expected");
        return;
      end
      want = expected_points.pop_front();
      if (got.x_right !== want.x_right)
        flag_mismatch($sformatf("x_right got %0d want %0d", got.x_right, want.x_right));
      if (got.x_left !== want.x_left)
        flag_mismatch($sformatf("x_left got %0d want %0d", got.x_left, want.x_left));
      if (got.y_lower !== want.y_lower)
        flag_mismatch($sformatf("y_lower got %0d want %0d", got.y_lower, want.y_lower));
      if (got.y_upper !== want.y_upper)
        flag_mismatch($sformatf("y_upper got %0d want %0d", got.y_upper, want.y_upper));
      if (got.color !== want.color)
        flag_mismatch($sformatf("pixel_color got %h want %h", got.color, want.color));
      if (got.done !== want.done)
        flag_mismatch($sformatf("done_res got %b want %b", got.done, want.done));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  meg_in_if  item_ch();
  meg_out_if result_ch();
  meg_cfg_if cfg_ch();

  midpoint_ellipse_generator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  ellipse_tracker tracker;
  int  words_sent = 0;
  bit  gaps_on = 0;
  bit  stalls_on = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  // result side: ready drops now and then while stalls are on
  always @(posedge clk) begin
    if (!stalls_on) begin
      result_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    ellipse_point_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.x_right = result_ch.x_right;
      got.x_left  = result_ch.x_left;
      got.y_lower = result_ch.y_lower;
      got.y_upper = result_ch.y_upper;
      got.color   = result_ch.pixel_color;
      got.done    = result_ch.done_res;
      tracker.check_point(got);
    end
  end

  // watchdog: too long without any handshake on any channel ends the run
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** midpoint_ellipse_generator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one restart/advance word, with an optional idle burst ahead of it
  task automatic send_word(bit restart);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.restart <= restart;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    tracker.note_word(restart);
    words_sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_reg(index, data);
  endtask

  // hold off input until every owed point has come back
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (tracker.expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly small axes so walks finish; now and then the extremes or a huge one
  function automatic logic [AXIS_W-1:0] pick_axis();
    int unsigned r;
    case ($urandom_range(0, 19))
      0: r = 0;
      1: r = (1 << AXIS_W) - 1;
      2: r = $urandom_range(1900, (1 << AXIS_W) - 1);
      default: r = $urandom_range(0, 24);
    endcase
    return r[AXIS_W-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int unsigned r;
    case ($urandom_range(0, 7))
      0: r = 0;
      1: r = (1 << COORD_BITS) - 1;
      default: r = $urandom;
    endcase
    return r[COORD_BITS-1:0];
  endfunction

  // random register update; unused bits of the data word carry noise
  task automatic configure_random();
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_IDX_W-1:0]  spare;
    if ($urandom_range(0, 1)) begin
      data = $urandom;
      data[COORD_BITS-1:0] = pick_coord();
      cfg_write(REG_CENTER_X, data);
    end
    if ($urandom_range(0, 1)) begin
      data = $urandom;
      data[COORD_BITS-1:0] = pick_coord();
      cfg_write(REG_CENTER_Y, data);
    end
    if ($urandom_range(0, 1)) begin
      data = $urandom;
      data[AXIS_W-1:0] = pick_axis();
      cfg_write(REG_SEMI_AXIS_X, data);
    end
    if ($urandom_range(0, 1)) begin
      data = $urandom;
      data[AXIS_W-1:0] = pick_axis();
      cfg_write(REG_SEMI_AXIS_Y, data);
    end
    if ($urandom_range(0, 2) == 0) cfg_write(REG_DRAW_COLOR, $urandom);
    if ($urandom_range(0, 9) == 0) begin
      spare = CFG_IDX_W'(REG_COUNT + $urandom_range(0, 2));
      cfg_write(spare, $urandom);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int span;
    int runs;
    logic [CFG_IDX_W-1:0] spare;
    item_ch.valid = 1'b0;
    item_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CENTER_X;
    cfg_ch.data = '0;
    result_ch.ready = 1'b1;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // advance before any restart: point (0,0) with done set
    send_word(1'b0);
    send_word(1'b0);
    drain();

    // small ellipse at the right edge, walked past done
    cfg_write(REG_CENTER_X, 32'hFFFF_FFFF);
    cfg_write(REG_CENTER_Y, 32'h0000_0000);
    cfg_write(REG_SEMI_AXIS_X, 32'd3);
    cfg_write(REG_SEMI_AXIS_Y, 32'd2);
    cfg_write(REG_DRAW_COLOR, 32'hFFFF_FFFF);
    cfg_ch.valid <= 1'b0;
    send_word(1'b1);
    repeat (8) send_word(1'b0);
    drain();

    // zero vertical semi-axis: the restart point is already the last one
    cfg_write(REG_SEMI_AXIS_Y, 32'd0);
    cfg_ch.valid <= 1'b0;
    send_word(1'b1);
    send_word(1'b0);
    drain();

    // largest axes around the opposite corner, plus an unused index
    cfg_write(REG_CENTER_X, 32'd0);
    cfg_write(REG_CENTER_Y, 32'h0000_0FFF);
    cfg_write(REG_SEMI_AXIS_X, 32'hFFFF_FFFF);
    cfg_write(REG_SEMI_AXIS_Y, 32'h0000_07FF);
    cfg_write(REG_DRAW_COLOR, 32'd0);
    spare = CFG_IDX_W'(REG_COUNT + $urandom_range(0, 2));
    cfg_write(spare, $urandom);
    cfg_ch.valid <= 1'b0;
    send_word(1'b1);
    repeat (3) send_word(1'b0);

    // random phases: new settings while idle, then a run of words
    while (words_sent < ITEM_COUNT) begin
      drain();
      gaps_on = (words_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      stalls_on <= (words_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      configure_random();
      if ($urandom_range(0, 6) != 0) begin
        // well-formed walk: usually a restart, then enough advances to finish
        if ($urandom_range(0, 4) != 0) send_word(1'b1);
        span = 2 * (int'(tracker.semi_x) + int'(tracker.semi_y)) + 4;
        if (span > MAX_ADVANCE) span = MAX_ADVANCE;
        runs = $urandom_range(1, span);
        repeat (runs) send_word(1'b0);
      end else begin
        // noise: restarts scattered at random
        runs = $urandom_range(1, 20);
        repeat (runs) send_word($urandom_range(0, 3) == 0);
      end
    end

    stalls_on <= 1'b0;
    drain();
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_points.size() == 0) begin
      $display("** midpoint_ellipse_generator: PASSED **");
    end else begin
      $display("** midpoint_ellipse_generator: FAILED **");
    end
    $finish;
  end
endmodule
